// File: hw/rtl/esc_pkg.sv
package esc_pkg;

    localparam int QUO_W     = 64;
    localparam int DEN_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP    = 3'd0,
        CFG_PRESS_A = 3'd1,
        CFG_PRESS_B = 3'd2,
        CFG_PRESS_9 = 3'd3,
        CFG_HUM_A   = 3'd4,
        CFG_HUM_B   = 3'd5
    } t_cfg_idx;

    // Results that ride along with the pressure division.
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        zero;
    } t_side;

endpackage

// File: hw/rtl/esc_div.sv
module esc_div import esc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [QUO_W-1:0]        i_num,
    input  logic signed [DEN_W-1:0] i_den,
    input  t_side                   i_side,
    output logic                    o_vld,
    output logic [QUO_W-1:0]        o_quo,
    output t_side                   o_side
);

    logic [QUO_W+1:0] r_v;
    logic [QUO_W-1:0] r_sh   [0:QUO_W];
    logic             r_neg  [0:QUO_W];
    t_side            r_sd   [0:QUO_W];
    logic [DEN_W-1:0] r_rem  [0:QUO_W-1];
    logic [DEN_W-1:0] r_md   [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo;
    t_side            r_side;
    logic [QUO_W-1:0] w_nnum;
    logic [DEN_W-1:0] w_nden;

    assign w_nnum = -i_num;
    assign w_nden = -i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QUO_W:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0]  <= i_num[QUO_W-1] ? w_nnum : i_num;
            r_md[0]  <= i_den[DEN_W-1] ? w_nden : i_den;
            r_neg[0] <= i_num[QUO_W-1] ^ i_den[DEN_W-1];
            r_rem[0] <= '0;
            r_sd[0]  <= i_side;
            r_quo    <= r_neg[QUO_W] ? -r_sh[QUO_W] : r_sh[QUO_W];
            r_side   <= r_sd[QUO_W];
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W:0] w_r2;
        logic [DEN_W:0] w_df;
        logic           w_ge;

        assign w_r2 = {r_rem[k], r_sh[k][QUO_W-1]};
        assign w_df = w_r2 - {1'b0, r_md[k]};
        assign w_ge = w_r2 >= {1'b0, r_md[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh[k+1]  <= {r_sh[k][QUO_W-2:0], w_ge};
                r_neg[k+1] <= r_neg[k];
                r_sd[k+1]  <= r_sd[k];
            end
        end

        if (k < QUO_W-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? w_df[DEN_W-1:0] : w_r2[DEN_W-1:0];
                    r_md[k+1]  <= r_md[k];
                end
            end
        end
    end

    assign o_vld  = r_v[QUO_W+1];
    assign o_quo  = r_quo;
    assign o_side = r_side;

endmodule

// File: hw/rtl/env_sensor_compensation.sv
// Channel   Direction  Handshake                   Payload
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
// sample    in         i_valid / o_ready           i_raw_temperature, i_raw_pressure,
//                                                  i_raw_humidity
// result    out        o_valid / i_ready           o_temperature_centi, o_pressure_q24_8,
//                                                  o_humidity_q22_10
// One word is accepted every cycle while o_ready is high; o_ready drops when the output buffer is full.
// Most of the pipeline depth is in the pressure division, which resolves one quotient bit per stage.
// Reset clears all valid bits and sets every coefficient register to zero.
// The whole pipeline holds when its two-word output buffer is full; nothing is lost.
module env_sensor_compensation import esc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [19:0]          i_raw_temperature,
    input  logic [19:0]          i_raw_pressure,
    input  logic [15:0]          i_raw_humidity,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_temperature_centi,
    output logic [31:0]          o_pressure_q24_8,
    output logic [16:0]          o_humidity_q22_10
);

    typedef struct packed {
        logic signed [49:0] lo;
        logic [31:0]        hi;
    } t_part;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
    } t_result;

    // Low 64 bits of a 64-bit word times a 17-bit signed factor, as two partial products.
    function automatic t_part mul_part(input logic [63:0] x, input logic signed [16:0] b);
        t_part              r;
        logic signed [32:0] xl;
        logic [31:0]        bx;
        xl   = $signed({1'b0, x[31:0]});
        bx   = {{15{b[16]}}, b};
        r.lo = xl * b;
        r.hi = x[63:32] * bx;
        return r;
    endfunction

    function automatic logic [63:0] part_sum(input t_part p);
        return {{14{p.lo[49]}}, p.lo} + {p.hi, 32'b0};
    endfunction

    // Coefficient registers
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_press_9;
    logic [39:0] r_hum_a;
    logic [31:0] r_hum_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_a     <= '0;
            r_press_b     <= '0;
            r_press_9     <= '0;
            r_hum_a       <= '0;
            r_hum_b       <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP:    r_temp_coeffs <= i_cfg_data[47:0];
                CFG_PRESS_A: r_press_a     <= i_cfg_data;
                CFG_PRESS_B: r_press_b     <= i_cfg_data;
                CFG_PRESS_9: r_press_9     <= i_cfg_data[15:0];
                CFG_HUM_A:   r_hum_a       <= i_cfg_data[39:0];
                CFG_HUM_B:   r_hum_b       <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [15:0]        w_c1;
    logic signed [15:0] w_c2, w_c3;
    logic [15:0]        w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [7:0]         w_h1, w_h3, w_h6;
    logic [15:0]        w_h2, w_h4, w_h5;

    assign w_c1 = r_temp_coeffs[15:0];
    assign w_c2 = r_temp_coeffs[31:16];
    assign w_c3 = r_temp_coeffs[47:32];
    assign w_p1 = r_press_a[15:0];
    assign w_p2 = r_press_a[31:16];
    assign w_p3 = r_press_a[47:32];
    assign w_p4 = r_press_a[63:48];
    assign w_p5 = r_press_b[15:0];
    assign w_p6 = r_press_b[31:16];
    assign w_p7 = r_press_b[47:32];
    assign w_p8 = r_press_b[63:48];
    assign w_p9 = r_press_9;
    assign w_h1 = r_hum_a[7:0];
    assign w_h2 = r_hum_a[23:8];
    assign w_h3 = r_hum_a[31:24];
    assign w_h6 = r_hum_a[39:32];
    assign w_h4 = r_hum_b[15:0];
    assign w_h5 = r_hum_b[31:16];

    // Flow control
    logic    w_en;
    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;
    logic    w_push, w_pop;
    t_result w_res;

    assign w_en    = !r_skid_vld;
    assign o_ready = w_en;

    // Front stages: fine temperature, temperature, humidity and the pressure operands
    logic [14:0]        r_vld;
    logic signed [17:0] r1_a;
    logic signed [16:0] r1_d;
    logic [20:0]        r_pd   [1:10];
    logic [15:0]        r_hraw [1:6];
    logic [31:0]        r_temp [5:15];
    logic [31:0]        r2_ac2, r2_dd;
    logic signed [20:0] r3_v1;
    logic [31:0]        r3_m;
    logic [31:0]        r4_fine;
    logic signed [32:0] r5_x1, r6_x1;
    logic [31:0]        r5_hv;
    logic [31:0]        r6_mag;
    logic [31:0]        r6_hm5, r6_hm6, r6_hm3;
    logic [63:0]        r7_sq;
    logic signed [48:0] r7_x1p5, r7_x1p2, r8_x1p5, r8_x1p2, r9_x1p5, r9_x1p2;
    logic [16:0]        r7_t1, r8_t1, r9_t1, r10_t1, r11_t1;
    logic [21:0]        r7_u;
    logic [31:0]        r7_w;
    logic [31:0]        r8_uw, r9_x, r10_xh2;
    logic [17:0]        r11_t2;
    logic [31:0]        r12_h, r13_h, r14_h;
    logic [31:0]        r13_ss, r14_ssh;
    logic [16:0]        r15_hum;
    t_part              r8_a, r8_b;
    logic [63:0]        r9_s6, r9_s3;
    logic [63:0]        r10_x2, r10_y1b;
    t_part              r11_yp;
    logic [63:0]        r11_npre;
    logic signed [30:0] r12_y1, r13_y1, r14_y1, r15_y1;
    t_part              r12_np;
    logic [63:0]        r13_num, r14_num, r15_num;

    logic signed [33:0] w_ac2, w_dd;
    logic signed [35:0] w_ddc3;
    logic [31:0]        w_t5;
    logic signed [32:0] w_nx1;
    logic [31:0]        w_hm5, w_hm6, w_hm3;
    logic [63:0]        w_sq;
    logic signed [48:0] w_x1p5, w_x1p2;
    logic [31:0]        w_t1pre, w_uw, w_xh2, w_t2pre, w_h;
    logic signed [33:0] w_ss;
    logic [31:0]        w_ssh, w_hf, w_hc;
    logic [63:0]        w_yps;

    assign w_ac2   = r1_a * w_c2;
    assign w_dd    = r1_d * r1_d;
    assign w_ddc3  = $signed(r2_dd[31:12]) * w_c3;
    assign w_t5    = {r4_fine[29:0], 2'b0} + r4_fine + 32'd128;
    assign w_nx1   = -r5_x1;
    assign w_hm5   = r5_hv * {{16{w_h5[15]}}, w_h5};
    assign w_hm6   = r5_hv * {{24{w_h6[7]}}, w_h6};
    assign w_hm3   = r5_hv * {24'b0, w_h3};
    assign w_sq    = r6_mag * r6_mag;
    assign w_x1p5  = r6_x1 * w_p5;
    assign w_x1p2  = r6_x1 * w_p2;
    assign w_t1pre = {2'b0, r_hraw[6], 14'b0} - {w_h4[11:0], 20'b0} - r6_hm5 + 32'd16384;
    assign w_uw    = {{10{r7_u[21]}}, r7_u} * r7_w;
    assign w_xh2   = r9_x * {{16{w_h2[15]}}, w_h2};
    assign w_t2pre = r10_xh2 + 32'd8192;
    assign w_h     = {{15{r11_t1[16]}}, r11_t1} * {{14{r11_t2[17]}}, r11_t2};
    assign w_ss    = $signed(r12_h[31:15]) * $signed(r12_h[31:15]);
    assign w_ssh   = {{7{r13_ss[31]}}, r13_ss[31:7]} * {24'b0, w_h1};
    assign w_hf    = r14_h - {{4{r14_ssh[31]}}, r14_ssh[31:4]};
    assign w_hc    = w_hf[31] ? 32'd0 :
                     (w_hf > 32'd419430400) ? 32'd419430400 : w_hf;
    assign w_yps   = part_sum(r11_yp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[13:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a      <= $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, w_c1, 1'b0});
            r1_d      <= $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, w_c1});
            r_pd[1]   <= 21'd1048576 - {1'b0, i_raw_pressure};
            r_hraw[1] <= i_raw_humidity;
            for (int k = 2; k <= 10; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
            for (int k = 2; k <= 6; k++) begin
                r_hraw[k] <= r_hraw[k-1];
            end
            for (int k = 6; k <= 15; k++) begin
                r_temp[k] <= r_temp[k-1];
            end

            r2_ac2  <= w_ac2[31:0];
            r2_dd   <= w_dd[31:0];
            r3_v1   <= $signed(r2_ac2[31:11]);
            r3_m    <= w_ddc3[31:0];
            r4_fine <= {{11{r3_v1[20]}}, r3_v1} + {{14{r3_m[31]}}, r3_m[31:14]};

            r_temp[5] <= {{8{w_t5[31]}}, w_t5[31:8]};
            r5_x1     <= $signed({r4_fine[31], r4_fine}) - 33'sd128000;
            r5_hv     <= r4_fine - 32'd76800;

            r6_mag <= r5_x1[32] ? w_nx1[31:0] : r5_x1[31:0];
            r6_x1  <= r5_x1;
            r6_hm5 <= w_hm5;
            r6_hm6 <= w_hm6;
            r6_hm3 <= w_hm3;

            r7_sq   <= w_sq;
            r7_x1p5 <= w_x1p5;
            r7_x1p2 <= w_x1p2;
            r7_t1   <= w_t1pre[31:15];
            r7_u    <= r6_hm6[31:10];
            r7_w    <= {{11{r6_hm3[31]}}, r6_hm3[31:11]} + 32'd32768;

            r8_a    <= mul_part(r7_sq, {w_p6[15], w_p6});
            r8_b    <= mul_part(r7_sq, {w_p3[15], w_p3});
            r8_x1p5 <= r7_x1p5;
            r8_x1p2 <= r7_x1p2;
            r8_uw   <= w_uw;
            r8_t1   <= r7_t1;

            r9_s6   <= part_sum(r8_a);
            r9_s3   <= part_sum(r8_b);
            r9_x1p5 <= r8_x1p5;
            r9_x1p2 <= r8_x1p2;
            r9_x    <= {{10{r8_uw[31]}}, r8_uw[31:10]} + 32'd2097152;
            r9_t1   <= r8_t1;

            r10_x2  <= r9_s6 + {r9_x1p5[46:0], 17'b0} + {{13{w_p4[15]}}, w_p4, 35'b0};
            r10_y1b <= {{8{r9_s3[63]}}, r9_s3[63:8]} + {{3{r9_x1p2[48]}}, r9_x1p2, 12'b0}
                       + 64'h0000_8000_0000_0000;
            r10_xh2 <= w_xh2;
            r10_t1  <= r9_t1;

            r11_yp   <= mul_part(r10_y1b, {1'b0, w_p1});
            r11_npre <= {12'b0, r_pd[10], 31'b0} - r10_x2;
            r11_t2   <= w_t2pre[31:14];
            r11_t1   <= r10_t1;

            r12_y1 <= $signed(w_yps[63:33]);
            r12_np <= mul_part(r11_npre, 17'sd3125);
            r12_h  <= w_h;

            r13_num <= part_sum(r12_np);
            r13_y1  <= r12_y1;
            r13_ss  <= w_ss[31:0];
            r13_h   <= r12_h;

            r14_num <= r13_num;
            r14_y1  <= r13_y1;
            r14_ssh <= w_ssh;
            r14_h   <= r13_h;

            r15_num <= r14_num;
            r15_y1  <= r14_y1;
            r15_hum <= w_hc[28:12];
        end
    end

    // Signed division of the scaled pressure numerator
    t_side       w_side_in, w_side_out;
    logic        w_dvld;
    logic [63:0] w_quo;

    assign w_side_in.temp = r_temp[15];
    assign w_side_in.hum  = r15_hum;
    assign w_side_in.zero = (r15_y1 == 31'sd0);

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld[14]),
        .i_num   (r15_num),
        .i_den   (r15_y1),
        .i_side  (w_side_in),
        .o_vld   (w_dvld),
        .o_quo   (w_quo),
        .o_side  (w_side_out)
    );

    // Back stages: pressure correction terms
    logic [4:0]  r_pvld;
    logic [63:0] rA_m0, rA_p, rB_sqq, rB_p, rB_e2, rC_pe2, rD_pe2, rD_e1, rE_sum;
    logic [31:0] rA_m1;
    t_part       rA_e2p, rC_e1p;
    t_side       rA_sd, rB_sd, rC_sd, rD_sd, rE_sd;
    logic [63:0] w_q, w_m0, w_e2s, w_e1s;
    logic [31:0] w_m1, w_press;

    assign w_q   = {{13{w_quo[63]}}, w_quo[63:13]};
    assign w_m0  = w_q[31:0] * w_q[31:0];
    assign w_m1  = w_q[31:0] * w_q[63:32];
    assign w_e2s = part_sum(rA_e2p);
    assign w_e1s = part_sum(rC_e1p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= '0;
        end else if (w_en) begin
            r_pvld <= {r_pvld[3:0], w_dvld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rA_m0  <= w_m0;
            rA_m1  <= w_m1;
            rA_e2p <= mul_part(w_quo, {w_p8[15], w_p8});
            rA_p   <= w_quo;
            rA_sd  <= w_side_out;

            rB_sqq <= rA_m0 + {rA_m1[30:0], 33'b0};
            rB_e2  <= {{19{w_e2s[63]}}, w_e2s[63:19]};
            rB_p   <= rA_p;
            rB_sd  <= rA_sd;

            rC_e1p <= mul_part(rB_sqq, {w_p9[15], w_p9});
            rC_pe2 <= rB_p + rB_e2;
            rC_sd  <= rB_sd;

            rD_e1  <= {{25{w_e1s[63]}}, w_e1s[63:25]};
            rD_pe2 <= rC_pe2;
            rD_sd  <= rC_sd;

            rE_sum <= rD_pe2 + rD_e1;
            rE_sd  <= rD_sd;
        end
    end

    assign w_press     = rE_sum[39:8] + {{12{w_p7[15]}}, w_p7, 4'b0};
    assign w_res.temp  = rE_sd.temp;
    assign w_res.press = rE_sd.zero ? 32'd0 : w_press;
    assign w_res.hum   = rE_sd.hum;

    // Two-word output buffer
    assign w_push = w_en && r_pvld[4];
    assign w_pop  = r_out_vld && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_pop) begin
                if (r_skid_vld) begin
                    r_out      <= r_skid;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= w_push;
                    r_out     <= w_res;
                end
            end else if (w_push) begin
                if (!r_out_vld) begin
                    r_out     <= w_res;
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid     <= w_res;
                    r_skid_vld <= 1'b1;
                end
            end
        end
    end

    assign o_valid             = r_out_vld;
    assign o_temperature_centi = r_out.temp;
    assign o_pressure_q24_8    = r_out.press;
    assign o_humidity_q22_10   = r_out.hum;

endmodule
